// ----- hw/rtl/lfu_pkg.sv -----
// Shared types, widths and default constants for the LFU cache table.
`default_nettype none

package lfu_pkg;

    // Payload widths
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 31;
    localparam int STAMP_W = 64;
    localparam int CFG_W   = 5;

    // Default sizing of the table
    localparam int CAPACITY_DEF    = 16;
    localparam int COUNT_WIDTH_DEF = 16;

    // Capacity register value after reset
    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    // Command codes
    typedef enum logic [0:0] {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } op_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } state_t;

    // Controls from the sequencer to the scan unit
    typedef struct packed {
        logic clear;
        logic eval;
    } scan_ctl_t;

    // Outcome flags of one scan
    typedef struct packed {
        logic match_found;
        logic free_found;
        logic victim_found;
    } scan_flags_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lfu_ram.sv -----
// Single write port, single registered read port entry memory.
`default_nettype none

module lfu_ram
    import lfu_pkg::*;
#(
    parameter int DEPTH  = CAPACITY_DEF,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 8
)
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register the read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/lfu_scan.sv -----
// Shared compare unit: key match, first free slot and LFU/LRU victim per entry.
`default_nettype none

module lfu_scan
    import lfu_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int IDX_W       = 4,
    parameter int NUM_W       = 5
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire scan_ctl_t              ctl,
    input  wire logic [IDX_W-1:0]       idx,
    input  wire logic                   entry_vld,
    input  wire logic [KEY_W-1:0]       ref_key,
    input  wire logic [KEY_W-1:0]       ent_key,
    input  wire logic [VAL_W-1:0]       ent_value,
    input  wire logic [COUNT_WIDTH-1:0] ent_count,
    input  wire logic [STAMP_W-1:0]     ent_stamp,
    output scan_flags_t                 flags,
    output logic [IDX_W-1:0]            match_idx,
    output logic [VAL_W-1:0]            match_value,
    output logic [COUNT_WIDTH-1:0]      match_count,
    output logic [IDX_W-1:0]            free_idx,
    output logic [IDX_W-1:0]            victim_idx,
    output logic [NUM_W-1:0]            used_cnt
);

    scan_flags_t            flags_reg;
    logic [NUM_W-1:0]       used_reg;
    logic [IDX_W-1:0]       match_idx_reg;
    logic [VAL_W-1:0]       match_value_reg;
    logic [COUNT_WIDTH-1:0] match_count_reg;
    logic [IDX_W-1:0]       free_idx_reg;
    logic [IDX_W-1:0]       victim_idx_reg;
    logic [COUNT_WIDTH-1:0] victim_count_reg;
    logic [STAMP_W-1:0]     victim_stamp_reg;

    logic is_match;
    logic is_free;
    logic is_victim;

    // Compare the current entry against the key and the best victim so far
    always_comb
    begin
        is_match  = ctl.eval && entry_vld && !flags_reg.match_found && (ent_key == ref_key);
        is_free   = ctl.eval && !entry_vld && !flags_reg.free_found;
        is_victim = ctl.eval && entry_vld &&
                    (!flags_reg.victim_found ||
                     (ent_count < victim_count_reg) ||
                     ((ent_count == victim_count_reg) && (ent_stamp < victim_stamp_reg)));
    end

    // Track flags and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
            used_reg  <= '0;
        end
        else if (ctl.clear)
        begin
            flags_reg <= '0;
            used_reg  <= '0;
        end
        else
        begin
            if (is_match)
            begin
                flags_reg.match_found <= 1'b1;
            end
            if (is_free)
            begin
                flags_reg.free_found <= 1'b1;
            end
            if (is_victim)
            begin
                flags_reg.victim_found <= 1'b1;
            end
            if (ctl.eval && entry_vld)
            begin
                used_reg <= used_reg + NUM_W'(1);
            end
        end
    end

    // Hold the candidate payloads
    always_ff @(posedge clk)
    begin
        if (is_match)
        begin
            match_idx_reg   <= idx;
            match_value_reg <= ent_value;
            match_count_reg <= ent_count;
        end
        if (is_free)
        begin
            free_idx_reg <= idx;
        end
        if (is_victim)
        begin
            victim_idx_reg   <= idx;
            victim_count_reg <= ent_count;
            victim_stamp_reg <= ent_stamp;
        end
    end

    assign flags       = flags_reg;
    assign match_idx   = match_idx_reg;
    assign match_value = match_value_reg;
    assign match_count = match_count_reg;
    assign free_idx    = free_idx_reg;
    assign victim_idx  = victim_idx_reg;
    assign used_cnt    = used_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/lfu_cache_table_top.sv -----
// Top level of the LFU cache table: sequencer, valid bits, stamp counter and outputs.
//
// Usage:
//   Command channel: raise start with op, lookup_key and data_value; the
//   transaction is taken at a rising edge where start is high and busy is low.
//   busy stays high while the table is scanned and updated.
//   Result channel: done pulses for one cycle with hit and read_value. There is
//   no back-pressure; the receiver must take the result in that cycle.
//   Configuration: cfg_we with cfg_wdata writes capacity_in_use (values above
//   CAPACITY act as CAPACITY); write it only while busy is low.
// Timing:
//   Each transaction passes from acceptance to done through the scan, where
//   the entry memory is read one entry per cycle into one shared compare
//   unit, the write-back and the output register. done shows in the cycle
//   busy drops, so a new transaction can be taken in that same cycle.
// Reset:
//   rst_n clears all valid bits, the stamp counter and the sequencer, and sets
//   capacity_in_use to 16. Entry payloads need no clearing.
`default_nettype none

module lfu_cache_table_top
    import lfu_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic                    op,
    input  wire logic signed [KEY_W-1:0] lookup_key,
    input  wire logic [VAL_W-1:0]        data_value,
    output logic                         done,
    output logic                         hit,
    output logic [VAL_W-1:0]             read_value,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_W-1:0]        cfg_wdata
);

    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int NUM_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (NUM_W > CFG_W) ? NUM_W : CFG_W;
    localparam int WORD_W = KEY_W + VAL_W + COUNT_WIDTH + STAMP_W;
    localparam int CNT_LO = STAMP_W;
    localparam int VAL_LO = STAMP_W + COUNT_WIDTH;
    localparam int KEY_LO = STAMP_W + COUNT_WIDTH + VAL_W;

    state_t                 state_reg, state_next;
    logic [CFG_W-1:0]       cfg_cap_reg;
    op_t                    op_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [VAL_W-1:0]       val_reg;
    logic [CMP_W-1:0]       cap_reg;
    logic [NUM_W-1:0]       iss_cnt_reg;
    logic                   eval_vld_reg;
    logic [IDX_W-1:0]       eval_idx_reg;
    logic [STAMP_W-1:0]     stamp_reg, stamp_next;
    logic [CAPACITY-1:0]    valid_reg, valid_next;
    logic                   done_reg, done_next;
    logic                   hit_reg, hit_next;
    logic [VAL_W-1:0]       rdval_reg, rdval_next;

    logic                   accept;
    logic                   issue;
    logic                   last_eval;
    logic [IDX_W-1:0]       rd_addr;
    logic [WORD_W-1:0]      rd_data;
    logic [CMP_W-1:0]       cfg_ext;
    logic [CMP_W-1:0]       cap_clip;
    scan_ctl_t              scan_ctl;
    scan_flags_t            flags;
    logic [IDX_W-1:0]       match_idx;
    logic [VAL_W-1:0]       match_value;
    logic [COUNT_WIDTH-1:0] match_count;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [IDX_W-1:0]       free_idx;
    logic [IDX_W-1:0]       victim_idx;
    logic [NUM_W-1:0]       used_cnt;
    logic                   use_free;
    logic                   wb_en;
    logic [IDX_W-1:0]       wb_addr;
    logic [WORD_W-1:0]      wb_word;
    logic                   set_valid;
    logic                   bump;

    // Handshake and scan pointers
    assign accept    = start && (state_reg == ST_IDLE);
    assign issue     = (state_reg == ST_SCAN) && (iss_cnt_reg < NUM_W'(CAPACITY));
    assign rd_addr   = iss_cnt_reg[IDX_W-1:0];
    assign last_eval = eval_vld_reg && (eval_idx_reg == IDX_W'(CAPACITY - 1));
    assign scan_ctl  = '{clear: accept, eval: eval_vld_reg};

    // Clip the capacity register to the table size
    assign cfg_ext  = CMP_W'(cfg_cap_reg);
    assign cap_clip = (cfg_ext > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : cfg_ext;

    // Entry memory
    lfu_ram #(
        .DEPTH  (CAPACITY),
        .ADDR_W (IDX_W),
        .DATA_W (WORD_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wb_en),
        .wr_addr (wb_addr),
        .wr_data (wb_word),
        .rd_en   (issue),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Shared compare unit
    lfu_scan #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .IDX_W       (IDX_W),
        .NUM_W       (NUM_W)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (scan_ctl),
        .idx         (eval_idx_reg),
        .entry_vld   (valid_reg[eval_idx_reg]),
        .ref_key     (key_reg),
        .ent_key     (rd_data[KEY_LO +: KEY_W]),
        .ent_value   (rd_data[VAL_LO +: VAL_W]),
        .ent_count   (rd_data[CNT_LO +: COUNT_WIDTH]),
        .ent_stamp   (rd_data[0 +: STAMP_W]),
        .flags       (flags),
        .match_idx   (match_idx),
        .match_value (match_value),
        .match_count (match_count),
        .free_idx    (free_idx),
        .victim_idx  (victim_idx),
        .used_cnt    (used_cnt)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last_eval)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Saturating touch of the matched count; pick free slot or victim on insert
    assign count_inc = (match_count == '1) ? match_count : match_count + COUNT_WIDTH'(1);
    assign use_free  = (CMP_W'(used_cnt) < cap_reg) && flags.free_found;

    // Write-back and result decision
    always_comb
    begin
        wb_en      = 1'b0;
        wb_addr    = match_idx;
        wb_word    = {key_reg, val_reg, COUNT_WIDTH'(1), stamp_reg};
        set_valid  = 1'b0;
        bump       = 1'b0;
        hit_next   = hit_reg;
        rdval_next = rdval_reg;
        done_next  = 1'b0;
        case (state_reg)
            ST_WRITE:
            begin
                done_next  = 1'b1;
                hit_next   = 1'b0;
                rdval_next = '0;
                if ((op_reg == OP_PUT) && (cap_reg == '0))
                begin
                    // put with zero capacity: drop
                end
                else if (flags.match_found)
                begin
                    hit_next   = 1'b1;
                    rdval_next = match_value;
                    wb_en      = 1'b1;
                    wb_addr    = match_idx;
                    wb_word    = {key_reg,
                                  (op_reg == OP_PUT) ? val_reg : match_value,
                                  count_inc, stamp_reg};
                    bump       = 1'b1;
                end
                else if (op_reg == OP_PUT)
                begin
                    if (use_free)
                    begin
                        wb_en     = 1'b1;
                        wb_addr   = free_idx;
                        set_valid = 1'b1;
                        bump      = 1'b1;
                    end
                    else if (flags.victim_found)
                    begin
                        wb_en     = 1'b1;
                        wb_addr   = victim_idx;
                        set_valid = 1'b1;
                        bump      = 1'b1;
                    end
                    else if (flags.free_found)
                    begin
                        wb_en     = 1'b1;
                        wb_addr   = free_idx;
                        set_valid = 1'b1;
                        bump      = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Advance stamp and valid bits
    always_comb
    begin
        stamp_next = bump ? stamp_reg + STAMP_W'(1) : stamp_reg;
        valid_next = valid_reg;
        if (set_valid)
        begin
            valid_next[wb_addr] = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cfg_cap_reg  <= CAP_RESET;
            iss_cnt_reg  <= '0;
            eval_vld_reg <= 1'b0;
            eval_idx_reg <= '0;
            stamp_reg    <= '0;
            valid_reg    <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            stamp_reg    <= stamp_next;
            valid_reg    <= valid_next;
            done_reg     <= done_next;
            eval_vld_reg <= issue;
            eval_idx_reg <= rd_addr;
            if (cfg_we)
            begin
                cfg_cap_reg <= cfg_wdata;
            end
            if (accept)
            begin
                iss_cnt_reg <= '0;
            end
            else if (issue)
            begin
                iss_cnt_reg <= iss_cnt_reg + NUM_W'(1);
            end
        end
    end

    // Capture the transaction and hold the result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= op_t'(op);
            key_reg <= $unsigned(lookup_key);
            val_reg <= data_value;
            cap_reg <= cap_clip;
        end
        hit_reg   <= hit_next;
        rdval_reg <= rdval_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign hit        = hit_reg;
    assign read_value = rdval_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/lfu_chk.sv -----
// Port-level checker for the LFU cache table and its bind to the top level.
`default_nettype none

module lfu_chk
    import lfu_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             done,
    input wire logic             hit,
    input wire logic [VAL_W-1:0] read_value
);

    // A result is shown only once the table is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // An accepted transaction makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // End of work always comes with a result
    a_fell_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // One strobe per transaction
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // A miss returns zero
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (read_value == '0))
        else $error("miss with nonzero read_value");

endmodule

bind lfu_cache_table_top lfu_chk u_lfu_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .hit        (hit),
    .read_value (read_value)
);

`default_nettype wire
